>>> hdl/tet_scaled_jacobian_core_assert.svh
// Assertion macros for the scaled Jacobian core
`ifndef TET_SCALED_JACOBIAN_CORE_ASSERT_SVH
`define TET_SCALED_JACOBIAN_CORE_ASSERT_SVH

// stalled item must stay valid and unchanged
`define TSJ_ASSERT_HOLD(lbl, vld, rdy, dat) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(dat))) else $error("stalled item changed");

// simple implication check
`define TSJ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error("implication failed");

`endif

>>> hdl/tsj_pkg.sv
package tsj_pkg;

    localparam int CW   = 16;
    localparam int FB   = 16;
    localparam int NVX  = 4;
    localparam int EW   = CW + 1;
    localparam int SQW  = 2 * EW - 1;
    localparam int LSW  = SQW + 2;
    localparam int PPW  = 2 * LSW;
    localparam int PW   = 3 * LSW;
    localparam int CXW  = 2 * EW + 1;
    localparam int JTW  = EW + CXW;
    localparam int JW   = JTW + 2;
    localparam int JMW  = JW - 1;
    localparam int JLO  = (JMW + 1) / 2;
    localparam int JHI  = JMW - JLO;
    localparam int DW   = 2 * JMW;
    localparam int RW   = DW + 1;
    localparam int QB   = 2 * FB + 2;
    localparam int SQB  = QB / 2;
    localparam int SRW  = SQB + 3;
    localparam int OW   = 18;
    localparam int IDW  = NVX * 3 * CW;
    localparam int ODW  = ((OW + 7) / 8) * 8;

    typedef struct packed {
        logic [DW-1:0] jsq;
        logic [DW-1:0] den;
        logic          neg;
        logic          dg;
    } tsj_ratio_t;

    typedef struct packed {
        logic [QB-1:0] q;
        logic          neg;
        logic          dg;
    } tsj_quot_t;

    typedef struct packed {
        logic [SQB-1:0] mag;
        logic           neg;
        logic           dg;
    } tsj_root_t;

endpackage

>>> hdl/tsj_front.sv
module tsj_front
    import tsj_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [IDW-1:0] in_data,
    output logic           out_valid,
    output tsj_ratio_t     out
);

    logic signed [CW-1:0]    v [NVX][3];

    logic [8:0]              vld_reg;

    logic signed [EW-1:0]    e_reg [6][3];
    logic signed [EW-1:0]    e_next [6][3];

    logic [SQW-1:0]          sq_reg [6][3];
    logic [SQW-1:0]          sq_next [6][3];
    logic signed [2*EW-1:0]  cp_reg [6];
    logic signed [2*EW-1:0]  cp_next [6];
    logic signed [EW-1:0]    e3a_reg [3];

    logic [LSW-1:0]          ls_reg [6];
    logic [LSW-1:0]          ls_next [6];
    logic signed [CXW-1:0]   cx_reg [3];
    logic signed [CXW-1:0]   cx_next [3];
    logic signed [EW-1:0]    e3b_reg [3];

    logic [PPW-1:0]          pa_reg [4];
    logic [PPW-1:0]          pa_next [4];
    logic [LSW-1:0]          lt_reg [4];
    logic [LSW-1:0]          lt_next [4];
    logic signed [JTW-1:0]   jt_reg [3];
    logic signed [JTW-1:0]   jt_next [3];

    logic [PPW-1:0]          pl_reg [4];
    logic [PPW-1:0]          pl_next [4];
    logic [PPW-1:0]          ph_reg [4];
    logic [PPW-1:0]          ph_next [4];
    logic signed [JW-1:0]    j_reg;
    logic signed [JW-1:0]    j_next;

    logic [PW-1:0]           prod_reg [4];
    logic [PW-1:0]           prod_next [4];
    logic [JMW-1:0]          jm_reg;
    logic [JMW-1:0]          jm_next;
    logic signed [JW-1:0]    jn;
    logic                    neg6_reg;

    logic [PW-1:0]           m01_reg;
    logic [PW-1:0]           m01_next;
    logic [PW-1:0]           m23_reg;
    logic [PW-1:0]           m23_next;
    logic [2*JHI-1:0]        hh_reg;
    logic [2*JHI-1:0]        hh_next;
    logic [JHI+JLO-1:0]      hl_reg;
    logic [JHI+JLO-1:0]      hl_next;
    logic [2*JLO-1:0]        ll_reg;
    logic [2*JLO-1:0]        ll_next;
    logic                    neg7_reg;

    logic [PW-1:0]           lmax_reg;
    logic [PW-1:0]           lmax_next;
    logic [DW-1:0]           jsq_reg;
    logic [DW-1:0]           jsq_next;
    logic                    neg8_reg;

    tsj_ratio_t              out_reg;
    tsj_ratio_t              out_next;

    always_comb
    begin
        for (int i = 0; i < NVX; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v[i][k] = in_data[(i*3+k)*CW +: CW];
            end
        end
    end

    // edges
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e_next[0][k] = EW'(v[1][k]) - EW'(v[0][k]);
            e_next[1][k] = EW'(v[2][k]) - EW'(v[1][k]);
            e_next[2][k] = EW'(v[0][k]) - EW'(v[2][k]);
            e_next[3][k] = EW'(v[3][k]) - EW'(v[0][k]);
            e_next[4][k] = EW'(v[3][k]) - EW'(v[1][k]);
            e_next[5][k] = EW'(v[3][k]) - EW'(v[2][k]);
        end
    end

    // component squares and cross partials of e2 x e0
    always_comb
    begin
        logic signed [2*EW-1:0] s;
        for (int i = 0; i < 6; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s = e_reg[i][k] * e_reg[i][k];
                sq_next[i][k] = s[SQW-1:0];
            end
        end
        cp_next[0] = e_reg[2][1] * e_reg[0][2];
        cp_next[1] = e_reg[2][2] * e_reg[0][1];
        cp_next[2] = e_reg[2][2] * e_reg[0][0];
        cp_next[3] = e_reg[2][0] * e_reg[0][2];
        cp_next[4] = e_reg[2][0] * e_reg[0][1];
        cp_next[5] = e_reg[2][1] * e_reg[0][0];
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ls_next[i] = LSW'(sq_reg[i][0]) + LSW'(sq_reg[i][1]) + LSW'(sq_reg[i][2]);
        end
        for (int k = 0; k < 3; k++)
        begin
            cx_next[k] = CXW'(cp_reg[2*k]) - CXW'(cp_reg[2*k+1]);
        end
    end

    // first pair products per vertex, Jacobian terms
    always_comb
    begin
        pa_next[0] = ls_reg[0] * ls_reg[2];
        pa_next[1] = ls_reg[0] * ls_reg[1];
        pa_next[2] = ls_reg[1] * ls_reg[2];
        pa_next[3] = ls_reg[3] * ls_reg[4];
        lt_next[0] = ls_reg[3];
        lt_next[1] = ls_reg[4];
        lt_next[2] = ls_reg[5];
        lt_next[3] = ls_reg[5];
        for (int k = 0; k < 3; k++)
        begin
            jt_next[k] = e3b_reg[k] * cx_reg[k];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pl_next[i] = pa_reg[i][LSW-1:0] * lt_reg[i];
            ph_next[i] = pa_reg[i][PPW-1:LSW] * lt_reg[i];
        end
        j_next = JW'(jt_reg[0]) + JW'(jt_reg[1]) + JW'(jt_reg[2]);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = (PW'(ph_reg[i]) << LSW) + PW'(pl_reg[i]);
        end
        jn = -j_reg;
        jm_next = j_reg[JW-1] ? jn[JMW-1:0] : j_reg[JMW-1:0];
    end

    always_comb
    begin
        m01_next = (prod_reg[1] > prod_reg[0]) ? prod_reg[1] : prod_reg[0];
        m23_next = (prod_reg[3] > prod_reg[2]) ? prod_reg[3] : prod_reg[2];
        hh_next  = jm_reg[JMW-1:JLO] * jm_reg[JMW-1:JLO];
        hl_next  = jm_reg[JMW-1:JLO] * jm_reg[JLO-1:0];
        ll_next  = jm_reg[JLO-1:0] * jm_reg[JLO-1:0];
    end

    always_comb
    begin
        lmax_next = (m23_reg > m01_reg) ? m23_reg : m01_reg;
        jsq_next  = (DW'(hh_reg) << (2*JLO)) + (DW'(hl_reg) << (JLO+1)) + DW'(ll_reg);
    end

    always_comb
    begin
        out_next.jsq = jsq_reg;
        out_next.den = (jsq_reg > DW'(lmax_reg)) ? jsq_reg : DW'(lmax_reg);
        out_next.neg = neg8_reg;
        out_next.dg  = (out_next.den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg    <= e_next;
            sq_reg   <= sq_next;
            cp_reg   <= cp_next;
            e3a_reg  <= e_reg[3];
            ls_reg   <= ls_next;
            cx_reg   <= cx_next;
            e3b_reg  <= e3a_reg;
            pa_reg   <= pa_next;
            lt_reg   <= lt_next;
            jt_reg   <= jt_next;
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            j_reg    <= j_next;
            prod_reg <= prod_next;
            jm_reg   <= jm_next;
            neg6_reg <= j_reg[JW-1];
            m01_reg  <= m01_next;
            m23_reg  <= m23_next;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            neg7_reg <= neg6_reg;
            lmax_reg <= lmax_next;
            jsq_reg  <= jsq_next;
            neg8_reg <= neg7_reg;
            out_reg  <= out_next;
        end
    end

    assign out_valid = vld_reg[8];
    assign out       = out_reg;

endmodule

>>> hdl/tsj_div.sv
module tsj_div
    import tsj_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  tsj_ratio_t in,
    output logic       out_valid,
    output tsj_quot_t  out
);

    logic [QB-1:0]  vld_reg;
    logic [RW-1:0]  r_reg [QB];
    logic [DW-1:0]  d_reg [QB];
    logic [QB-1:0]  q_reg [QB];
    logic [QB-1:0]  neg_reg;
    logic [QB-1:0]  dg_reg;

    // restoring division, one quotient bit per stage, msb first
    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [RW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [QB-1:0] q_in;
        logic          n_in;
        logic          z_in;
        logic          ge;
        logic [RW-1:0] r_next;
        logic [QB-1:0] q_next;

        if (i == 0)
        begin : g_first
            assign r_in = RW'(in.jsq);
            assign d_in = in.den;
            assign q_in = '0;
            assign n_in = in.neg;
            assign z_in = in.dg;
        end
        else
        begin : g_rest
            assign r_in = r_reg[i-1] << 1;
            assign d_in = d_reg[i-1];
            assign q_in = q_reg[i-1];
            assign n_in = neg_reg[i-1];
            assign z_in = dg_reg[i-1];
        end

        always_comb
        begin
            ge     = (r_in >= RW'(d_in));
            r_next = ge ? (r_in - RW'(d_in)) : r_in;
            q_next = {q_in[QB-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]   <= r_next;
                d_reg[i]   <= d_in;
                q_reg[i]   <= q_next;
                neg_reg[i] <= n_in;
                dg_reg[i]  <= z_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out.q     = q_reg[QB-1];
    assign out.neg   = neg_reg[QB-1];
    assign out.dg    = dg_reg[QB-1];

endmodule

>>> hdl/tsj_isqrt.sv
module tsj_isqrt
    import tsj_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  tsj_quot_t in,
    output logic      out_valid,
    output tsj_root_t out
);

    logic [SQB-1:0] vld_reg;
    logic [QB-1:0]  qs_reg [SQB];
    logic [SRW-1:0] rem_reg [SQB];
    logic [SQB-1:0] root_reg [SQB];
    logic [SQB-1:0] neg_reg;
    logic [SQB-1:0] dg_reg;

    // digit-by-digit root, one result bit per stage
    for (genvar i = 0; i < SQB; i++)
    begin : g_step
        logic [QB-1:0]  q_in;
        logic [SRW-1:0] rem_in;
        logic [SQB-1:0] root_in;
        logic           n_in;
        logic           z_in;
        logic [SRW-1:0] acc;
        logic [SRW-1:0] trial;
        logic           ge;

        if (i == 0)
        begin : g_first
            assign q_in    = in.q;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = in.neg;
            assign z_in    = in.dg;
        end
        else
        begin : g_rest
            assign q_in    = qs_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign n_in    = neg_reg[i-1];
            assign z_in    = dg_reg[i-1];
        end

        always_comb
        begin
            acc   = {rem_in[SRW-3:0], q_in[QB-1:QB-2]};
            trial = SRW'({root_in, 2'b01});
            ge    = (acc >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qs_reg[i]   <= q_in << 2;
                rem_reg[i]  <= ge ? (acc - trial) : acc;
                root_reg[i] <= {root_in[SQB-2:0], ge};
                neg_reg[i]  <= n_in;
                dg_reg[i]   <= z_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SQB-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[SQB-1];
    assign out.mag   = root_reg[SQB-1];
    assign out.neg   = neg_reg[SQB-1];
    assign out.dg    = dg_reg[SQB-1];

endmodule

>>> hdl/tet_scaled_jacobian_core.sv
// Pipeline: 9 geometry stages, 34 divider stages, 17 square-root stages and 1 output
// register; the divider and the square root each produce one result bit per stage.
// Throughput: one item per cycle; a stall on the result side freezes the whole pipe.
// Reset: rst_n asynchronous, active low; clears all valid bits, payload is not reset.
module tet_scaled_jacobian_core
    import tsj_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x, ... vertex3_z
    input  logic [IDW-1:0] s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // scaled_jacobian, zero fill
    output logic [ODW-1:0] m_axis_tdata,
    // degenerate
    output logic           m_axis_tuser
);

    logic           en;
    logic           fr_valid;
    tsj_ratio_t     fr_out;
    logic           dv_valid;
    tsj_quot_t      dv_out;
    logic           sq_valid;
    tsj_root_t      sq_out;

    logic           ovld_reg;
    logic [OW-1:0]  res_reg;
    logic [OW-1:0]  res_next;
    logic           dg_reg;

    assign en            = !ovld_reg || m_axis_tready;
    assign s_axis_tready = en;

    tsj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (fr_valid),
        .out       (fr_out)
    );

    tsj_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in        (fr_out),
        .out_valid (dv_valid),
        .out       (dv_out)
    );

    tsj_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in        (dv_out),
        .out_valid (sq_valid),
        .out       (sq_out)
    );

    always_comb
    begin
        if (sq_out.dg)
        begin
            res_next = '0;
        end
        else if (sq_out.neg)
        begin
            res_next = -OW'(sq_out.mag);
        end
        else
        begin
            res_next = OW'(sq_out.mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            ovld_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            dg_reg  <= sq_out.dg;
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {{(ODW-OW){1'b0}}, res_reg};
    assign m_axis_tuser  = dg_reg;

endmodule

>>> hdl/tsj_checker.sv
`include "tet_scaled_jacobian_core_assert.svh"

module tsj_checker
    import tsj_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    input  logic           s_axis_tready,
    input  logic [IDW-1:0] s_axis_tdata,
    input  logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    input  logic [ODW-1:0] m_axis_tdata,
    input  logic           m_axis_tuser
);

    logic signed [OW-1:0] sj;

    assign sj = m_axis_tdata[OW-1:0];

    `TSJ_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata)
    `TSJ_ASSERT_IMPL(a_dg_zero, m_axis_tvalid && m_axis_tuser, sj == '0)
    `TSJ_ASSERT_IMPL(a_range, m_axis_tvalid, (sj <= 18'sd92682) && (sj >= -18'sd92682))
    `TSJ_ASSERT_IMPL(a_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready)

endmodule

bind tet_scaled_jacobian_core tsj_checker u_tsj_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tsj_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_POINT    = 400;

    typedef struct {
        logic [17:0] sj;
        logic        dg;
    } quality_t;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [IDW-1:0] s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [ODW-1:0] m_axis_tdata;
    logic           m_axis_tuser;

    logic [IDW-1:0] tet_q[$];
    quality_t       quality_q[$];
    int             n_sent;
    int             gap_left;
    int             stall_left;
    int             idle_cycles;
    bit             failed;

    tet_scaled_jacobian_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    function automatic quality_t scaled_jacobian(logic [IDW-1:0] tet);
        longint     v[4][3];
        longint     e[6][3];
        longint     cx[3];
        longint     jac;
        longint     ls[6];
        logic [255:0] prod[4];
        logic [255:0] lmax;
        logic [255:0] jabs;
        logic [255:0] jsq;
        logic [255:0] den;
        logic [255:0] quo;
        logic [63:0]  q;
        logic [63:0]  res;
        logic [63:0]  bitv;
        logic [17:0]  mag;
        quality_t     r;
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v[i][k] = longint'($signed(tet[(i*3+k)*CW +: CW]));
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            e[0][k] = v[1][k] - v[0][k];
            e[1][k] = v[2][k] - v[1][k];
            e[2][k] = v[0][k] - v[2][k];
            e[3][k] = v[3][k] - v[0][k];
            e[4][k] = v[3][k] - v[1][k];
            e[5][k] = v[3][k] - v[2][k];
        end
        cx[0] = e[2][1] * e[0][2] - e[2][2] * e[0][1];
        cx[1] = e[2][2] * e[0][0] - e[2][0] * e[0][2];
        cx[2] = e[2][0] * e[0][1] - e[2][1] * e[0][0];
        jac = e[3][0] * cx[0] + e[3][1] * cx[1] + e[3][2] * cx[2];
        for (int i = 0; i < 6; i++)
        begin
            ls[i] = e[i][0] * e[i][0] + e[i][1] * e[i][1] + e[i][2] * e[i][2];
        end
        prod[0] = 256'(ls[0]) * 256'(ls[2]) * 256'(ls[3]);
        prod[1] = 256'(ls[0]) * 256'(ls[1]) * 256'(ls[4]);
        prod[2] = 256'(ls[1]) * 256'(ls[2]) * 256'(ls[5]);
        prod[3] = 256'(ls[3]) * 256'(ls[4]) * 256'(ls[5]);
        lmax = prod[0];
        for (int i = 1; i < 4; i++)
        begin
            if (prod[i] > lmax)
            begin
                lmax = prod[i];
            end
        end
        jabs = (jac < 0) ? 256'(-jac) : 256'(jac);
        jsq  = jabs * jabs;
        den  = (jsq > lmax) ? jsq : lmax;
        if (den == 0)
        begin
            r.sj = '0;
            r.dg = 1'b1;
            return r;
        end
        quo = (jsq << (2 * FB + 1)) / den;
        q   = quo[63:0];
        res  = 0;
        bitv = 64'h1 << 62;
        while (bitv > q)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (q >= res + bitv)
            begin
                q   = q - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        mag  = res[17:0];
        r.sj = (jac < 0) ? -mag : mag;
        r.dg = 1'b0;
        return r;
    endfunction

    function automatic logic [IDW-1:0] pack_tet(int c[12]);
        logic [IDW-1:0] t;
        for (int i = 0; i < 12; i++)
        begin
            t[i*CW +: CW] = c[i][CW-1:0];
        end
        return t;
    endfunction

    function automatic int pick_gap(int phase);
        int r;
        r = $urandom_range(99);
        if (phase == 0 || r < 65)
        begin
            return 0;
        end
        else if (r < 95)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 10);
    endfunction

    function automatic int rand_coord(int span);
        if (span == 0)
        begin
            return $signed(16'($urandom()));
        end
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            n_sent        = 0;
            gap_left      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                quality_q.push_back(scaled_jacobian(s_axis_tdata));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (n_sent == DRAIN_POINT && quality_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (tet_q.size() != 0)
                begin
                    s_axis_tdata  <= tet_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    gap_left = pick_gap((n_sent / 90) % 3);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        quality_t exp_r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    = 0;
            idle_cycles   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (quality_q.size() == 0)
                begin
                    $display("%0t: unexpected item sj=%h dg=%b", $time,
                             m_axis_tdata[17:0], m_axis_tuser);
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = quality_q.pop_front();
                    if (m_axis_tdata[17:0] !== exp_r.sj)
                    begin
                        $display("%0t: scaled_jacobian exp %h got %h", $time,
                                 exp_r.sj, m_axis_tdata[17:0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser !== exp_r.dg)
                    begin
                        $display("%0t: degenerate exp %b got %b", $time,
                                 exp_r.dg, m_axis_tuser);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(((n_sent + 45) / 90) % 3);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int c[12];
        int span;
        int kind;
        failed        = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;

        // all zero: degenerate
        c = '{default: 0};
        tet_q.push_back(pack_tet(c));
        // four coincident points: degenerate
        c = '{-32768, 32767, -1, -32768, 32767, -1, -32768, 32767, -1, -32768, 32767, -1};
        tet_q.push_back(pack_tet(c));
        // collinear: flat
        c = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 5, 5, 5};
        tet_q.push_back(pack_tet(c));
        // coplanar: flat
        c = '{0, 0, 7, 100, 0, 7, 0, 100, 7, -50, 30, 7};
        tet_q.push_back(pack_tet(c));
        // right corner, both orientations
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
        tet_q.push_back(pack_tet(c));
        c = '{0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1};
        tet_q.push_back(pack_tet(c));
        // regular tetrahedron, both orientations
        c = '{1000, 1000, 1000, 1000, -1000, -1000, -1000, 1000, -1000, -1000, -1000, 1000};
        tet_q.push_back(pack_tet(c));
        c = '{1000, 1000, 1000, -1000, 1000, -1000, 1000, -1000, -1000, -1000, -1000, 1000};
        tet_q.push_back(pack_tet(c));
        // coordinate extremes
        c = '{-32768, -32768, -32768, 32767, -32768, -32768,
              -32768, 32767, -32768, -32768, -32768, 32767};
        tet_q.push_back(pack_tet(c));
        c = '{32767, 32767, 32767, -32768, 32767, 32767,
              32767, -32768, 32767, 32767, 32767, -32768};
        tet_q.push_back(pack_tet(c));
        c = '{-32768, 32767, -32768, 32767, -32768, 32767,
              32767, 32767, -32768, -32768, -32768, -32768};
        tet_q.push_back(pack_tet(c));
        // sliver: nearly flat
        c = '{0, 0, 0, 32767, 0, 0, 0, 32767, 0, 16000, 16000, 1};
        tet_q.push_back(pack_tet(c));
        // needle
        c = '{-32768, 0, 0, 32767, 0, 0, 0, 1, 0, 0, 0, 1};
        tet_q.push_back(pack_tet(c));
        // one distinct point
        c = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 6, 5, 5};
        tet_q.push_back(pack_tet(c));

        for (int n = 0; n < 850; n++)
        begin
            kind = $urandom_range(9);
            span = (kind < 4) ? 0 : (kind < 7) ? $urandom_range(300, 1) : 3;
            for (int i = 0; i < 12; i++)
            begin
                c[i] = rand_coord(span);
            end
            if (kind == 8)
            begin
                // force flat or degenerate by copying vertices or axis planes
                c[9]  = c[0];
                c[10] = c[1];
                c[11] = c[2];
                if ($urandom_range(1))
                begin
                    c[3:5] = c[0:2];
                end
            end
            else if (kind == 9)
            begin
                c[2] = c[5];
                c[8] = c[5];
                c[11] = c[5];
            end
            tet_q.push_back(pack_tet(c));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (tet_q.size() == 0 && !s_axis_tvalid && quality_q.size() == 0);
        repeat (100) @(posedge clk);
        if (!failed && quality_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
